// File: rtl/tzf_pkg.sv
`default_nettype none

package tzf_pkg;

    // default geometry of the zone grid
    localparam int ZONES_PER_ROW_DEF = 8;
    localparam int ZONE_COUNT_DEF    = 64;

    // input word command codes
    localparam logic CMD_ZONE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // gesture codes
    localparam logic [1:0] GEST_NONE = 2'd0;
    localparam logic [1:0] GEST_UP   = 2'd1;
    localparam logic [1:0] GEST_DOWN = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_NEAR_LIMIT   = 3'd0;
    localparam logic [2:0] REG_MIN_MOVE     = 3'd1;
    localparam logic [2:0] REG_MIN_TIME     = 3'd2;
    localparam logic [2:0] REG_MAX_TIME     = 3'd3;
    localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd4;

    // configuration reset values
    localparam logic [11:0] NEAR_LIMIT_RST   = 12'd200;
    localparam logic [2:0]  MIN_MOVE_RST     = 3'd2;
    localparam logic [15:0] MIN_TIME_RST     = 16'd100;
    localparam logic [15:0] MAX_TIME_RST     = 16'd800;
    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd500;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef struct packed {
        logic        cmd;
        logic        has_target;
        logic [11:0] distance_mm;
        logic        last_zone;
    } t_in_word;

    typedef struct packed {
        logic [1:0] gesture;
        logic [6:0] active_zones;
    } t_out_word;

    typedef struct packed {
        logic [11:0] near_limit_mm;
        logic [2:0]  min_move_rows;
        logic [15:0] min_time_ms;
        logic [15:0] max_time_ms;
        logic [15:0] idle_timeout_ms;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_N1,
        ST_MUL_N2,
        ST_CMP,
        ST_FINISH
    } t_trk_state;

    // tracker status toward the top level
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [1:0] gesture;
    } t_trk_stat;

endpackage

`default_nettype wire

// File: rtl/tzf_zone_acc.sv
`default_nettype none

module tzf_zone_acc #(
    parameter int ZONES_PER_ROW = tzf_pkg::ZONES_PER_ROW_DEF,
    parameter int ZONE_COUNT    = tzf_pkg::ZONE_COUNT_DEF,
    parameter int HIT_W         = 7,
    parameter int SUM_W         = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_sample,
    input  wire logic              i_has_target,
    input  wire logic [11:0]       i_distance_mm,
    input  wire logic [11:0]       i_near_limit_mm,
    input  wire logic              i_clear,
    output logic      [HIT_W-1:0]  o_hits,
    output logic      [SUM_W-1:0]  o_row_sum
);
    import tzf_pkg::*;

    localparam int ROWS  = (ZONE_COUNT + ZONES_PER_ROW - 1) / ZONES_PER_ROW;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = $clog2(ZONES_PER_ROW);
    localparam int CNT_W = $clog2(ZONE_COUNT + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [HIT_W-1:0] r_hits, n_hits;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             in_range;
    logic             near;

    // zone position tracked as column and row, no divide needed
    always_comb begin
        in_range = (r_cnt < CNT_W'(ZONE_COUNT));
        near     = i_has_target && (i_distance_mm <= i_near_limit_mm);
        n_cnt    = r_cnt;
        n_col    = r_col;
        n_row    = r_row;
        n_hits   = r_hits;
        n_sum    = r_sum;
        if (i_clear) begin
            n_cnt  = '0;
            n_col  = '0;
            n_row  = '0;
            n_hits = '0;
            n_sum  = '0;
        end else if (i_sample && in_range) begin
            if (near) begin
                n_hits = r_hits + HIT_W'(1);
                n_sum  = r_sum + SUM_W'(r_row);
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_col == COL_W'(ZONES_PER_ROW - 1)) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_hits <= '0;
            r_sum  <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_col  <= n_col;
            r_row  <= n_row;
            r_hits <= n_hits;
            r_sum  <= n_sum;
        end
    end

    assign o_hits    = r_hits;
    assign o_row_sum = r_sum;

endmodule

`default_nettype wire

// File: rtl/tzf_mul_unit.sv
`default_nettype none

module tzf_mul_unit #(
    parameter int A_W = 14,
    parameter int B_W = 7
) (
    input  wire logic               i_clk,
    input  wire logic [A_W-1:0]     i_op_a,
    input  wire logic [B_W-1:0]     i_op_b,
    output logic      [A_W+B_W-1:0] o_prod
);
    import tzf_pkg::*;

    logic [A_W+B_W-1:0] r_prod;

    // shared multiplier, product registered every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= (A_W+B_W)'(i_op_a) * (A_W+B_W)'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/tzf_tracker.sv
`default_nettype none

module tzf_tracker #(
    parameter int HIT_W = 7,
    parameter int SUM_W = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_tick,
    input  wire logic              i_out_free,
    input  wire tzf_pkg::t_cfg     i_cfg,
    input  wire logic [HIT_W-1:0]  i_hits,
    input  wire logic [SUM_W-1:0]  i_row_sum,
    output tzf_pkg::t_trk_stat     o_stat
);
    import tzf_pkg::*;

    localparam int OA_W = (SUM_W > 2 * HIT_W) ? SUM_W : 2 * HIT_W;
    localparam int P_W  = OA_W + HIT_W;

    t_trk_state       r_state, n_state;
    logic             r_tracking, n_tracking;
    logic             r_reported, n_reported;
    logic [SUM_W-1:0] r_entry_sum, n_entry_sum;
    logic [HIT_W-1:0] r_entry_hits, n_entry_hits;
    logic [15:0]      r_elapsed, n_elapsed;
    logic [15:0]      r_idle, n_idle;
    logic             r_idle_flag, n_idle_flag;
    logic [P_W-1:0]   r_prod_a, n_prod_a;
    logic [P_W-1:0]   r_prod_b, n_prod_b;
    logic [1:0]       r_gesture, n_gesture;

    logic [OA_W-1:0]  mul_a;
    logic [HIT_W-1:0] mul_b;
    logic [P_W-1:0]   prod;
    logic [P_W-1:0]   diff;
    logic             done;

    tzf_mul_unit #(
        .A_W (OA_W),
        .B_W (HIT_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (prod)
    );

    // sequencer: decide, then four products and a compare when due, then finish
    always_comb begin
        n_state      = r_state;
        n_tracking   = r_tracking;
        n_reported   = r_reported;
        n_entry_sum  = r_entry_sum;
        n_entry_hits = r_entry_hits;
        n_elapsed    = r_elapsed;
        n_idle       = r_idle;
        n_idle_flag  = r_idle_flag;
        n_prod_a     = r_prod_a;
        n_prod_b     = r_prod_b;
        n_gesture    = r_gesture;
        mul_a        = '0;
        mul_b        = '0;
        done         = 1'b0;
        diff         = (r_prod_a >= r_prod_b) ? (r_prod_a - r_prod_b) : (r_prod_b - r_prod_a);

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EVAL;
                end else if (i_tick) begin
                    n_elapsed = (r_elapsed == TIMER_MAX) ? TIMER_MAX : r_elapsed + 16'd1;
                    n_idle    = (r_idle == TIMER_MAX) ? TIMER_MAX : r_idle + 16'd1;
                    if (n_idle >= i_cfg.idle_timeout_ms && !r_idle_flag) begin
                        n_tracking  = 1'b0;
                        n_idle_flag = 1'b1;
                    end
                end
            end
            ST_EVAL: begin
                n_gesture = GEST_NONE;
                n_state   = ST_FINISH;
                if (!r_tracking) begin
                    if (i_hits >= HIT_W'(2)) begin
                        n_entry_sum  = i_row_sum;
                        n_entry_hits = i_hits;
                        n_elapsed    = '0;
                        n_reported   = 1'b0;
                        n_tracking   = 1'b1;
                    end
                end else if (i_hits == '0) begin
                    n_tracking = 1'b0;
                end else if (!r_reported && r_elapsed >= i_cfg.min_time_ms) begin
                    if (r_elapsed > i_cfg.max_time_ms) begin
                        n_reported = 1'b1;
                    end else begin
                        n_state = ST_MUL_A;
                    end
                end
            end
            ST_MUL_A: begin
                // current sum times entry hits
                mul_a   = OA_W'(i_row_sum);
                mul_b   = r_entry_hits;
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                // entry sum times current hits
                mul_a    = OA_W'(r_entry_sum);
                mul_b    = i_hits;
                n_prod_a = prod;
                n_state  = ST_MUL_N1;
            end
            ST_MUL_N1: begin
                mul_a    = OA_W'(i_hits);
                mul_b    = r_entry_hits;
                n_prod_b = prod;
                n_state  = ST_MUL_N2;
            end
            ST_MUL_N2: begin
                // threshold scaled by both hit counts
                mul_a   = prod[OA_W-1:0];
                mul_b   = HIT_W'(i_cfg.min_move_rows);
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (diff >= prod) begin
                    n_reported = 1'b1;
                    n_gesture  = (r_prod_a < r_prod_b) ? GEST_UP : GEST_DOWN;
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    done        = 1'b1;
                    n_idle      = '0;
                    n_idle_flag = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tracking   <= 1'b0;
            r_reported   <= 1'b0;
            r_entry_sum  <= '0;
            r_entry_hits <= '0;
            r_elapsed    <= '0;
            r_idle       <= '0;
            r_idle_flag  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tracking   <= n_tracking;
            r_reported   <= n_reported;
            r_entry_sum  <= n_entry_sum;
            r_entry_hits <= n_entry_hits;
            r_elapsed    <= n_elapsed;
            r_idle       <= n_idle;
            r_idle_flag  <= n_idle_flag;
        end
    end

    // products and gesture code are payload
    always_ff @(posedge i_clk) begin
        r_prod_a  <= n_prod_a;
        r_prod_b  <= n_prod_b;
        r_gesture <= n_gesture;
    end

    assign o_stat.busy    = (r_state != ST_IDLE);
    assign o_stat.done    = done;
    assign o_stat.gesture = r_gesture;

endmodule

`default_nettype wire

// File: rtl/tof_zone_flick_gesture_detector.sv
`default_nettype none

// channel  | signals                          | word
// ---------+----------------------------------+-------------------------------------
// input    | i_in_valid, o_in_stall, i_in_data | cmd, has_target, distance_mm, last_zone
// output   | o_out_valid, i_out_stall, o_out_data | gesture, active_zones
// config   | i_cfg_we, i_cfg_index, i_cfg_data | registers 0..4, no read-back
//
// Ticks and non-final zone samples do not stall the input. A final zone
// sample stalls it through evaluation, the cross-multiplied compare when
// that runs, and finish; all products go through one shared registered multiplier.
// The finish step waits while the output register is full and stalled.
// Reset is synchronous, active low; it restores register defaults.

module tof_zone_flick_gesture_detector #(
    parameter int ZONES_PER_ROW = tzf_pkg::ZONES_PER_ROW_DEF,
    parameter int ZONE_COUNT    = tzf_pkg::ZONE_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire tzf_pkg::t_in_word i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output tzf_pkg::t_out_word     o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);
    import tzf_pkg::*;

    localparam int ROWS  = (ZONE_COUNT + ZONES_PER_ROW - 1) / ZONES_PER_ROW;
    localparam int HIT_W = $clog2(ZONE_COUNT + 1);
    localparam int SUM_RAW = $clog2(ZONE_COUNT * (ROWS - 1) + 1);
    localparam int SUM_W = (SUM_RAW > 0) ? SUM_RAW : 1;

    t_cfg       r_cfg;
    t_trk_stat  trk_stat;
    logic       accept;
    logic       sample;
    logic       start;
    logic       tick;
    logic       out_free;
    logic [HIT_W-1:0] hits;
    logic [SUM_W-1:0] row_sum;
    logic [HIT_W+6:0] hits_ext;
    logic       r_out_valid;
    t_out_word  r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit_mm   <= NEAR_LIMIT_RST;
            r_cfg.min_move_rows   <= MIN_MOVE_RST;
            r_cfg.min_time_ms     <= MIN_TIME_RST;
            r_cfg.max_time_ms     <= MAX_TIME_RST;
            r_cfg.idle_timeout_ms <= IDLE_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NEAR_LIMIT:   r_cfg.near_limit_mm   <= i_cfg_data[11:0];
                REG_MIN_MOVE:     r_cfg.min_move_rows   <= i_cfg_data[2:0];
                REG_MIN_TIME:     r_cfg.min_time_ms     <= i_cfg_data;
                REG_MAX_TIME:     r_cfg.max_time_ms     <= i_cfg_data;
                REG_IDLE_TIMEOUT: r_cfg.idle_timeout_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input handshake and word decode
    assign o_in_stall = trk_stat.busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign sample     = accept && (i_in_data.cmd == CMD_ZONE);
    assign start      = sample && i_in_data.last_zone;
    assign tick       = accept && (i_in_data.cmd == CMD_TICK);
    assign out_free   = !r_out_valid || !i_out_stall;

    tzf_zone_acc #(
        .ZONES_PER_ROW (ZONES_PER_ROW),
        .ZONE_COUNT    (ZONE_COUNT),
        .HIT_W         (HIT_W),
        .SUM_W         (SUM_W)
    ) u_acc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sample        (sample),
        .i_has_target    (i_in_data.has_target),
        .i_distance_mm   (i_in_data.distance_mm),
        .i_near_limit_mm (r_cfg.near_limit_mm),
        .i_clear         (trk_stat.done),
        .o_hits          (hits),
        .o_row_sum       (row_sum)
    );

    tzf_tracker #(
        .HIT_W (HIT_W),
        .SUM_W (SUM_W)
    ) u_trk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_tick     (tick),
        .i_out_free (out_free),
        .i_cfg      (r_cfg),
        .i_hits     (hits),
        .i_row_sum  (row_sum),
        .o_stat     (trk_stat)
    );

    assign hits_ext = (HIT_W + 7)'(hits);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (trk_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (trk_stat.done) begin
            r_out_data.gesture      <= trk_stat.gesture;
            r_out_data.active_zones <= hits_ext[6:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
